// ===== src/sha_pkg.sv =====
// SHA-256 package: round constants, initial hash values and round helpers.
// Used by the schedule/round unit and the top-level sequencer.
package sha_pkg;

   localparam int unsigned RoundCount = 64;

   typedef logic [31:0] word_type;

   // Return the round constant for round t.
   function automatic word_type round_const(input logic [5:0] t);
      word_type k [0:63];
      k = '{
         32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
         32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
         32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
         32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
         32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
         32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
         32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
         32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
         32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
         32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
         32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
         32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
         32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
         32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
         32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
         32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
      return k[t];
   endfunction

   // Return initial hash word i.
   function automatic word_type init_hash(input logic [2:0] i);
      word_type v [0:7];
      v = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
            32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
      return v[i];
   endfunction

   function automatic word_type rotr(input word_type x, input int unsigned n);
      return (x >> n) | (x << (32 - n));
   endfunction

   // Control from the sequencer to the round unit.
   typedef struct packed {
      logic load;      // copy chain into working registers
      logic round;     // perform one round
      logic fold;      // add working registers into chain
      logic init;      // chain back to initial values
      logic [5:0] t;   // round number
   } round_ctl_type;

endpackage

// ===== src/sha256_stream_hash_top.sv =====
// SHA-256 streaming hash top level: byte buffer, padding and round sequencer.
// Depends on sha_pkg and sha_round.
//
//  channel | dir | tdata                  | tuser / tlast
//  req     | in  | [7:0] data_byte        | tuser: byte_valid, tlast: last_byte
//  rsp     | out | [31:0] word, [34:32] ix| tlast: last_word
//
// A byte is taken while idle; a filling byte starts a compression.
// A final transaction passes through padding, then one or two compressions
// (a last byte that fills the block first adds its own compression),
// then eight digest words, one per cycle as rsp_tready allows.
// Reset is synchronous; req_tready is low during compression and digest output.
module sha256_stream_hash_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] byte_valid
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] digest_word, [34:32] word_index, zero fill
   output logic        rsp_tlast    // last_word
);
   typedef enum logic [2:0] {S_IDLE, S_PAD, S_LOAD, S_ROUND, S_FOLD, S_OUT} state_type;

   state_type state_ff;
   sha_pkg::word_type blk_ff [16];   // block bytes, most significant byte of a word first
   sha_pkg::word_type pad_blk [16];
   sha_pkg::word_type byte_word;
   logic [5:0] fill_ff;
   logic [63:0] len_ff;
   logic [5:0] t_ff;
   logic [2:0] oidx_ff;
   logic final_ff;     // message ended: padding pending
   logic second_ff;    // length block still to compress
   logic pad_done_ff;  // running compression is the last of the message
   sha_pkg::round_ctl_type ctl;
   sha_pkg::word_type blk_word, rd_word;
   logic acc;
   logic [5:0] pad_base;

   assign acc = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign blk_word = blk_ff[t_ff[3:0]];

   always_comb begin
      ctl.load  = (state_ff == S_LOAD);
      ctl.round = (state_ff == S_ROUND);
      ctl.fold  = (state_ff == S_FOLD);
      ctl.init  = (state_ff == S_OUT) && rsp_tready && (oidx_ff == 3'd7);
      ctl.t     = t_ff;
   end

   sha_round u_round (
      .clock(clock), .reset(reset), .ctl(ctl), .blk_word(blk_word),
      .rd_index(oidx_ff), .rd_word(rd_word)
   );

   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tdata  = {5'd0, oidx_ff, rd_word};
   assign rsp_tlast  = (oidx_ff == 3'd7);
   assign pad_base   = fill_ff;

   // Merge the incoming byte into its word lane.
   always_comb begin
      byte_word = blk_ff[fill_ff[5:2]];
      byte_word[{~fill_ff[1:0], 3'b000} +: 8] = req_tdata;
   end

   // Build the padded block: held bytes, 0x80, zeros and, if room, the length.
   always_comb begin
      for (int w = 0; w < 16; w++) begin
         for (int b = 0; b < 4; b++) begin
            if (6'(4*w + b) < pad_base) begin
               pad_blk[w][8*(3-b) +: 8] = blk_ff[w][8*(3-b) +: 8];
            end else if (6'(4*w + b) == pad_base) begin
               pad_blk[w][8*(3-b) +: 8] = 8'h80;
            end else begin
               pad_blk[w][8*(3-b) +: 8] = 8'h00;
            end
         end
      end
      if (pad_base <= 6'd55) begin
         pad_blk[14] = len_ff[63:32];
         pad_blk[15] = len_ff[31:0];
      end
   end

   // Sequence bytes, padding, rounds and digest output.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; fill_ff <= '0; len_ff <= '0; t_ff <= '0;
         oidx_ff <= '0; final_ff <= 1'b0; second_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (acc) begin
                  final_ff <= req_tlast;
                  if (req_tuser) begin
                     blk_ff[fill_ff[5:2]] <= byte_word;
                     len_ff <= len_ff + 64'd8;
                     fill_ff <= fill_ff + 6'd1;
                     if (fill_ff == 6'd63) begin
                        state_ff <= S_LOAD;
                     end else if (req_tlast) begin
                        state_ff <= S_PAD;
                     end
                  end else if (req_tlast) begin
                     state_ff <= S_PAD;
                  end
               end
            end
            S_PAD: begin
               // Write 0x80, zeros and, if room, the length.
               for (int i = 0; i < 16; i++) blk_ff[i] <= pad_blk[i];
               second_ff <= (pad_base > 6'd55);
               final_ff <= 1'b0;
               state_ff <= S_LOAD;
            end
            S_LOAD: begin
               t_ff <= '0;
               state_ff <= S_ROUND;
            end
            S_ROUND: begin
               t_ff <= t_ff + 6'd1;
               if (t_ff == 6'(sha_pkg::RoundCount - 1)) state_ff <= S_FOLD;
            end
            S_FOLD: begin
               fill_ff <= '0;
               priority if (final_ff) begin
                  state_ff <= S_PAD;
               end else if (second_ff) begin
                  for (int i = 0; i < 14; i++) blk_ff[i] <= '0;
                  blk_ff[14] <= len_ff[63:32];
                  blk_ff[15] <= len_ff[31:0];
                  second_ff <= 1'b0;
                  oidx_ff <= '0;
                  state_ff <= S_LOAD;
                  final_ff <= 1'b0;
               end else begin
                  state_ff <= (pad_done_ff) ? S_OUT : S_IDLE;
                  oidx_ff <= '0;
               end
            end
            S_OUT: begin
               if (rsp_tready) begin
                  oidx_ff <= oidx_ff + 3'd1;
                  if (oidx_ff == 3'd7) begin
                     state_ff <= S_IDLE; len_ff <= '0; fill_ff <= '0;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // Track whether the running compression is the last of the message.
   always_ff @(posedge clock) begin
      if (reset) begin
         pad_done_ff <= 1'b0;
      end else if (state_ff == S_PAD) begin
         pad_done_ff <= (pad_base <= 6'd55);
      end else if (state_ff == S_FOLD && second_ff) begin
         pad_done_ff <= 1'b1;
      end else if (state_ff == S_OUT) begin
         pad_done_ff <= 1'b0;
      end
   end
endmodule

// ===== src/sha_round.sv =====
// SHA-256 round unit: chain hash, working registers and message schedule window.
// Depends on sha_pkg; one round per cycle under control of the sequencer.
module sha_round (
   input  logic                   clock,
   input  logic                   reset,
   input  sha_pkg::round_ctl_type ctl,
   input  sha_pkg::word_type      blk_word,   // block word t, used in rounds 0..15
   input  logic [2:0]             rd_index,
   output sha_pkg::word_type      rd_word
);
   sha_pkg::word_type chain_ff [8];
   sha_pkg::word_type wrk_ff [8];
   sha_pkg::word_type win_ff [16];
   sha_pkg::word_type w_in, t1, t2, s0, s1, w2, w15;
   sha_pkg::word_type a, b, c, d, e, f, g, h;

   assign a = wrk_ff[0]; assign b = wrk_ff[1]; assign c = wrk_ff[2]; assign d = wrk_ff[3];
   assign e = wrk_ff[4]; assign f = wrk_ff[5]; assign g = wrk_ff[6]; assign h = wrk_ff[7];

   // Form the schedule word and the two round temporaries.
   always_comb begin
      w2  = win_ff[4'(ctl.t - 6'd2)];
      w15 = win_ff[4'(ctl.t - 6'd15)];
      s0  = sha_pkg::rotr(w15, 7) ^ sha_pkg::rotr(w15, 18) ^ (w15 >> 3);
      s1  = sha_pkg::rotr(w2, 17) ^ sha_pkg::rotr(w2, 19) ^ (w2 >> 10);
      if (ctl.t < 6'd16) begin
         w_in = blk_word;
      end else begin
         w_in = s1 + win_ff[4'(ctl.t - 6'd7)] + s0 + win_ff[ctl.t[3:0]];
      end
      t1 = h + (sha_pkg::rotr(e, 6) ^ sha_pkg::rotr(e, 11) ^ sha_pkg::rotr(e, 25))
           + ((e & f) ^ (~e & g)) + sha_pkg::round_const(ctl.t) + w_in;
      t2 = (sha_pkg::rotr(a, 2) ^ sha_pkg::rotr(a, 13) ^ sha_pkg::rotr(a, 22))
           + ((a & b) ^ (a & c) ^ (b & c));
   end

   // Hold chain; reset and init restore the initial values.
   always_ff @(posedge clock) begin
      for (int i = 0; i < 8; i++) begin
         if (reset || ctl.init) begin
            chain_ff[i] <= sha_pkg::init_hash(3'(i));
         end else if (ctl.fold) begin
            chain_ff[i] <= chain_ff[i] + wrk_ff[i];
         end
      end
   end

   // Advance working registers and the schedule window.
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         for (int i = 0; i < 8; i++) wrk_ff[i] <= chain_ff[i];
      end else if (ctl.round) begin
         wrk_ff[0] <= t1 + t2;
         wrk_ff[1] <= a; wrk_ff[2] <= b; wrk_ff[3] <= c;
         wrk_ff[4] <= d + t1;
         wrk_ff[5] <= e; wrk_ff[6] <= f; wrk_ff[7] <= g;
         win_ff[ctl.t[3:0]] <= w_in;
      end
   end

   assign rd_word = chain_ff[rd_index];
endmodule

// ===== src/sha_checker.sv =====
// Port-level checker for the SHA-256 streaming hash top level.
// Bound to sha256_stream_hash_top; sees only its ports.
module sha_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic        rsp_tlast
);
   // Never accept input while a digest is being shown.
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(rsp_tvalid && req_tready)) else $error("input taken during digest");
   // Last flag matches index seven.
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tdata[34:32] == 3'd7)))
      else $error("last flag mismatch");
   // Index advances by one after each accepted word that is not last.
   a_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast) |=>
      (rsp_tvalid && rsp_tdata[34:32] == $past(rsp_tdata[34:32]) + 3'd1))
      else $error("index did not advance");
   // Stalled word holds.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled word changed");
endmodule

bind sha256_stream_hash_top sha_checker u_sha_checker (
   .clock(clock), .reset(reset), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
   .rsp_tlast(rsp_tlast)
);
